@@ src/nc2d_pkg.sv @@
// Shared definitions for the normalised RGB convolution block.
// Holds default sizes, register indexes, command codes and the item structs.
// No dependencies.
package nc2d_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;
  localparam int DEF_MAX_RADIUS = 2;
  localparam int DEF_COEF_BITS  = 16;

  localparam logic [10:0] RST_IMAGE_WIDTH  = 11'd1024;
  localparam logic [10:0] RST_IMAGE_HEIGHT = 11'd1024;
  localparam logic [1:0]  RST_RADIUS_X     = 2'd1;
  localparam logic [1:0]  RST_RADIUS_Y     = 2'd1;

  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_RADIUS_X     = 2'd2,
    REG_RADIUS_Y     = 2'd3
  } cfg_reg_t;

  localparam logic [1:0] CMD_COEF  = 2'd0;
  localparam logic [1:0] CMD_PIXEL = 2'd1;
  localparam logic [1:0] CMD_DRAIN = 2'd2;

  typedef struct packed {
    logic [1:0]         command;
    logic [4:0]         coef_index;
    logic signed [15:0] coef_value;
    logic [7:0]         pixel_red;
    logic [7:0]         pixel_green;
    logic [7:0]         pixel_blue;
  } in_item_t;

  typedef struct packed {
    logic [9:0] out_x;
    logic [9:0] out_y;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       frame_end;
  } out_item_t;

endpackage

@@ src/nc2d_ram.sv @@
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module nc2d_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ src/normalized_conv2d_rgb.sv @@
// Top level of the normalised RGB convolution: row store, kernel store, tap sequencer,
// per-channel accumulators and a bit-serial rounding divider.
// Depends on nc2d_pkg and nc2d_ram.
//
//  channel | direction | signals                         | payload
//  --------+-----------+---------------------------------+----------------------
//  in      | input     | in_valid / in_ready             | in_item_t in_data
//  out     | output    | out_valid / out_ready           | out_item_t out_data
//  cfg     | input     | cfg_valid / cfg_ready (always 1)| cfg_index, cfg_data
//
// A coefficient load is written in S_IDLE; a pixel or drain with no result passes S_DEC.
// A result's time is set by the one read port of the row store, which is visited once
// per kernel tap (kw*kh taps, kw, kh the kernel sides), and by the eight-step divider.
// Reset is synchronous and active low; neither memory is cleared.
// A finished result waits in the output register while the next item is taken; the
// sequencer stalls only when a new result is ready and that register is still full.
module normalized_conv2d_rgb import nc2d_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int MAX_RADIUS = DEF_MAX_RADIUS,
  parameter int COEF_BITS  = DEF_COEF_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  cfg_reg_t    cfg_index,
  input  logic [10:0] cfg_data
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int RDW   = $clog2(MAX_RADIUS + 1);
  localparam int KDIM  = 2 * MAX_RADIUS + 1;
  localparam int KTAPS = KDIM * KDIM;
  localparam int KIW   = $clog2(KTAPS);
  localparam int TW    = $clog2(KDIM);
  localparam int RING  = 3 * MAX_RADIUS + 2;
  localparam int SW    = $clog2(RING);
  localparam int TAPW  = $clog2(KTAPS + 1);
  localparam int PW    = COEF_BITS + 9;
  localparam int ACCW  = PW + TAPW;
  localparam int SUMW  = COEF_BITS + TAPW;
  localparam int NW    = ACCW + 3;
  localparam int LAGW  = $clog2(MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 2);
  localparam int XS    = CW + 2;
  localparam int YS    = HW + 2;

  typedef enum logic [7:0] {
    S_IDLE = 8'b00000001,
    S_DEC  = 8'b00000010,
    S_TAP  = 8'b00000100,
    S_WAIT = 8'b00001000,
    S_PREP = 8'b00010000,
    S_CHK  = 8'b00100000,
    S_DIV  = 8'b01000000,
    S_OUT  = 8'b10000000
  } state_t;

  state_t state_r, state_nxt;

  // configuration registers
  logic [10:0]     cfg_w_r, cfg_h_r;
  logic [1:0]      cfg_rx_r, cfg_ry_r;

  // frame state
  logic            frame_open_r, frame_open_nxt;
  logic [WW-1:0]   lat_w_r, lat_w_nxt, eff_w;
  logic [HW-1:0]   lat_h_r, lat_h_nxt, eff_h;
  logic [RDW-1:0]  lat_rx_r, lat_rx_nxt, eff_rx;
  logic [RDW-1:0]  lat_ry_r, lat_ry_nxt, eff_ry;
  logic [LAGW-1:0] lag_r, lag_nxt, eff_lag;
  logic [LAGW-1:0] diff_r, diff_nxt;
  logic [CW-1:0]   in_col_r, in_col_nxt, out_col_r, out_col_nxt;
  logic [HW-1:0]   in_row_r, in_row_nxt, out_row_r, out_row_nxt;
  logic [SW-1:0]   in_slot_r, in_slot_nxt, out_slot_r, out_slot_nxt;
  in_item_t        item_r, item_nxt;

  // tap sequencer
  logic [TW-1:0]   ti_r, ti_nxt, tj_r, tj_nxt;
  logic [KIW-1:0]  kidx_r, kidx_nxt;
  logic [SW-1:0]   tslot_r, tslot_nxt;
  logic [XS-1:0]   sx_v;
  logic [YS-1:0]   sy_v;
  logic            tap_inb;
  logic [SW:0]     start_slot;

  // read and multiply pipeline
  logic            iss1_r, iss2_r, v1_r, v2_r;
  logic [23:0]     pix_q;
  logic [COEF_BITS-1:0] coef_q;
  logic signed [COEF_BITS-1:0] cf2_r;
  logic signed [PW-1:0]   p_r [3];
  logic signed [PW-1:0]   p_nxt [3];
  logic signed [ACCW-1:0] acc_r [3];
  logic signed [ACCW-1:0] acc_nxt [3];
  logic signed [SUMW-1:0] asum_r, asum_nxt;

  // rounding divider
  logic signed [SUMW:0]   asx, a_abs;
  logic signed [NW-1:0]   s_ext [3];
  logic signed [NW-1:0]   s_adj [3];
  logic [NW-1:0]          n_r [3];
  logic [NW-1:0]          n_nxt [3];
  logic [NW-1:0]          d_r, d_nxt, dsh_r, dsh_nxt;
  logic [7:0]             q_r [3];
  logic [7:0]             q_nxt [3];
  logic [2:0]             neg_r, neg_nxt, ovf_r, ovf_nxt;
  logic                   azero_r, azero_nxt;
  logic [2:0]             cnt_r, cnt_nxt;
  logic [7:0]             chan [3];

  // output register
  logic            out_valid_r, out_valid_nxt, out_load;
  out_item_t       out_data_r, out_data_nxt;
  logic [CW+9:0]   ox_ext;
  logic [HW+9:0]   oy_ext;

  // memory ports
  logic            row_we, coef_we, row_re;
  logic [COEF_BITS+15:0] cv_ext;

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cv_ext    = {{COEF_BITS{1'b0}}, in_data.coef_value};
  assign row_re    = (state_r == S_TAP);

  // Clamped configuration, taken into the frame registers at the first pixel.
  always_comb begin
    if (cfg_w_r == '0) begin
      eff_w = WW'(1);
    end else if (32'(cfg_w_r) > 32'(MAX_WIDTH)) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(cfg_w_r);
    end
    if (cfg_h_r == '0) begin
      eff_h = HW'(1);
    end else if (32'(cfg_h_r) > 32'(MAX_HEIGHT)) begin
      eff_h = HW'(MAX_HEIGHT);
    end else begin
      eff_h = HW'(cfg_h_r);
    end
    eff_rx  = (32'(cfg_rx_r) > 32'(MAX_RADIUS)) ? RDW'(MAX_RADIUS) : RDW'(cfg_rx_r);
    eff_ry  = (32'(cfg_ry_r) > 32'(MAX_RADIUS)) ? RDW'(MAX_RADIUS) : RDW'(cfg_ry_r);
    eff_lag = LAGW'(eff_ry) * LAGW'(eff_w) + LAGW'(eff_rx);
  end

  // Tap geometry for the current kernel position.
  always_comb begin
    sx_v    = XS'(out_col_r) + XS'(ti_r) - XS'(lat_rx_r);
    sy_v    = YS'(out_row_r) + YS'(tj_r) - YS'(lat_ry_r);
    tap_inb = !sx_v[XS-1] && (sx_v < XS'(lat_w_r)) &&
              !sy_v[YS-1] && (sy_v < YS'(lat_h_r));
    start_slot = (SW+1)'(out_slot_r) + (SW+1)'(RING) - (SW+1)'(lat_ry_r);
    if (start_slot >= (SW+1)'(RING)) begin
      start_slot = start_slot - (SW+1)'(RING);
    end
  end

  nc2d_ram #(.WIDTH(24), .DEPTH(RING << CW)) u_row_ram (
    .clk   (clk),
    .we    (row_we),
    .waddr ({in_slot_r, in_col_r}),
    .wdata ({item_r.pixel_blue, item_r.pixel_green, item_r.pixel_red}),
    .re    (row_re),
    .raddr ({tslot_r, sx_v[CW-1:0]}),
    .rdata (pix_q)
  );

  nc2d_ram #(.WIDTH(COEF_BITS), .DEPTH(KTAPS)) u_coef_ram (
    .clk   (clk),
    .we    (coef_we),
    .waddr (KIW'(in_data.coef_index)),
    .wdata (cv_ext[COEF_BITS-1:0]),
    .re    (row_re),
    .raddr (kidx_r),
    .rdata (coef_q)
  );

  // Divider front end: fold the sign of the weight sum into the numerator.
  always_comb begin
    asx   = (SUMW+1)'(asum_r);
    a_abs = asum_r[SUMW-1] ? -asx : asx;
    for (int c = 0; c < 3; c++) begin
      s_ext[c] = NW'(acc_r[c]);
      s_adj[c] = asum_r[SUMW-1] ? -s_ext[c] : s_ext[c];
      chan[c]  = (azero_r || neg_r[c]) ? 8'd0 : (ovf_r[c] ? 8'hFF : q_r[c]);
    end
    ox_ext = (CW+10)'(out_col_r);
    oy_ext = (HW+10)'(out_row_r);
  end

  always_comb begin
    state_nxt      = state_r;
    frame_open_nxt = frame_open_r;
    lat_w_nxt      = lat_w_r;
    lat_h_nxt      = lat_h_r;
    lat_rx_nxt     = lat_rx_r;
    lat_ry_nxt     = lat_ry_r;
    lag_nxt        = lag_r;
    diff_nxt       = diff_r;
    in_col_nxt     = in_col_r;
    in_row_nxt     = in_row_r;
    in_slot_nxt    = in_slot_r;
    out_col_nxt    = out_col_r;
    out_row_nxt    = out_row_r;
    out_slot_nxt   = out_slot_r;
    item_nxt       = item_r;
    ti_nxt         = ti_r;
    tj_nxt         = tj_r;
    kidx_nxt       = kidx_r;
    tslot_nxt      = tslot_r;
    asum_nxt       = asum_r;
    d_nxt          = d_r;
    dsh_nxt        = dsh_r;
    neg_nxt        = neg_r;
    ovf_nxt        = ovf_r;
    azero_nxt      = azero_r;
    cnt_nxt        = cnt_r;
    out_data_nxt   = out_data_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_load       = 1'b0;
    row_we         = 1'b0;
    coef_we        = 1'b0;
    for (int c = 0; c < 3; c++) begin
      acc_nxt[c] = acc_r[c];
      n_nxt[c]   = n_r[c];
      q_nxt[c]   = q_r[c];
      p_nxt[c]   = $signed({1'b0, pix_q[8*c +: 8]}) * $signed(coef_q);
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          item_nxt = in_data;
          if (in_data.command == CMD_COEF) begin
            coef_we = (32'(in_data.coef_index) < 32'(KTAPS));
          end else if (in_data.command == CMD_PIXEL) begin
            state_nxt = S_DEC;
            if (!frame_open_r) begin
              frame_open_nxt = 1'b1;
              lat_w_nxt      = eff_w;
              lat_h_nxt      = eff_h;
              lat_rx_nxt     = eff_rx;
              lat_ry_nxt     = eff_ry;
              lag_nxt        = eff_lag;
              diff_nxt       = '0;
              in_col_nxt     = '0;
              in_row_nxt     = '0;
              in_slot_nxt    = '0;
              out_col_nxt    = '0;
              out_row_nxt    = '0;
              out_slot_nxt   = '0;
            end
          end else if (in_data.command == CMD_DRAIN) begin
            state_nxt = S_DEC;
          end
        end
      end
      S_DEC: begin
        state_nxt = S_IDLE;
        ti_nxt    = '0;
        tj_nxt    = '0;
        kidx_nxt  = '0;
        tslot_nxt = SW'(start_slot);
        asum_nxt  = '0;
        for (int c = 0; c < 3; c++) begin
          acc_nxt[c] = '0;
        end
        if (item_r.command == CMD_PIXEL) begin
          if (in_row_r < lat_h_r) begin
            row_we   = 1'b1;
            diff_nxt = diff_r + 1'b1;
            if (((CW+1)'(in_col_r) + 1'b1) >= (CW+1)'(lat_w_r)) begin
              in_col_nxt  = '0;
              in_row_nxt  = in_row_r + 1'b1;
              in_slot_nxt = (in_slot_r == SW'(RING - 1)) ? '0 : in_slot_r + 1'b1;
            end else begin
              in_col_nxt = in_col_r + 1'b1;
            end
            if (diff_r >= lag_r) begin
              state_nxt = S_TAP;
            end
          end
        end else if (frame_open_r && (in_row_r >= lat_h_r) && (out_row_r < lat_h_r)) begin
          state_nxt = S_TAP;
        end
      end
      S_TAP: begin
        kidx_nxt = kidx_r + 1'b1;
        if (ti_r == TW'({lat_rx_r, 1'b0})) begin
          ti_nxt = '0;
          if (tj_r == TW'({lat_ry_r, 1'b0})) begin
            state_nxt = S_WAIT;
          end else begin
            tj_nxt    = tj_r + 1'b1;
            tslot_nxt = (tslot_r == SW'(RING - 1)) ? '0 : tslot_r + 1'b1;
          end
        end else begin
          ti_nxt = ti_r + 1'b1;
        end
      end
      S_WAIT: begin
        if (!iss1_r && !iss2_r) begin
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        state_nxt = S_CHK;
        d_nxt     = NW'(a_abs) << 1;
        azero_nxt = (asum_r == '0);
        for (int c = 0; c < 3; c++) begin
          n_nxt[c] = NW'((s_adj[c] <<< 1) + NW'(a_abs));
        end
      end
      S_CHK: begin
        state_nxt = S_DIV;
        dsh_nxt   = d_r << 7;
        cnt_nxt   = '0;
        for (int c = 0; c < 3; c++) begin
          neg_nxt[c] = n_r[c][NW-1];
          ovf_nxt[c] = (n_r[c] >= (d_r << 8));
        end
      end
      S_DIV: begin
        // One quotient bit per cycle; the clamp flags cover everything above 255.
        dsh_nxt = dsh_r >> 1;
        cnt_nxt = cnt_r + 1'b1;
        for (int c = 0; c < 3; c++) begin
          if (n_r[c] >= dsh_r) begin
            n_nxt[c] = n_r[c] - dsh_r;
            q_nxt[c] = {q_r[c][6:0], 1'b1};
          end else begin
            q_nxt[c] = {q_r[c][6:0], 1'b0};
          end
        end
        if (cnt_r == 3'd7) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_load               = 1'b1;
          state_nxt              = S_IDLE;
          out_valid_nxt          = 1'b1;
          diff_nxt               = diff_r - 1'b1;
          out_data_nxt.out_x     = ox_ext[9:0];
          out_data_nxt.out_y     = oy_ext[9:0];
          out_data_nxt.out_red   = chan[0];
          out_data_nxt.out_green = chan[1];
          out_data_nxt.out_blue  = chan[2];
          out_data_nxt.frame_end = 1'b0;
          if (((CW+1)'(out_col_r) + 1'b1) >= (CW+1)'(lat_w_r)) begin
            out_col_nxt  = '0;
            out_row_nxt  = out_row_r + 1'b1;
            out_slot_nxt = (out_slot_r == SW'(RING - 1)) ? '0 : out_slot_r + 1'b1;
            if (HW'(out_row_r + 1'b1) >= lat_h_r) begin
              out_data_nxt.frame_end = 1'b1;
              frame_open_nxt         = 1'b0;
            end
          end else begin
            out_col_nxt = out_col_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (v2_r) begin
      asum_nxt = asum_r + SUMW'(cf2_r);
      for (int c = 0; c < 3; c++) begin
        acc_nxt[c] = acc_r[c] + ACCW'(p_r[c]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      frame_open_r <= 1'b0;
      lat_w_r      <= WW'(1);
      lat_h_r      <= HW'(1);
      lat_rx_r     <= '0;
      lat_ry_r     <= '0;
      lag_r        <= '0;
      diff_r       <= '0;
      in_col_r     <= '0;
      in_row_r     <= '0;
      in_slot_r    <= '0;
      out_col_r    <= '0;
      out_row_r    <= '0;
      out_slot_r   <= '0;
      out_valid_r  <= 1'b0;
      iss1_r       <= 1'b0;
      iss2_r       <= 1'b0;
      v1_r         <= 1'b0;
      v2_r         <= 1'b0;
      cnt_r        <= '0;
      cfg_w_r      <= RST_IMAGE_WIDTH;
      cfg_h_r      <= RST_IMAGE_HEIGHT;
      cfg_rx_r     <= RST_RADIUS_X;
      cfg_ry_r     <= RST_RADIUS_Y;
    end else begin
      state_r      <= state_nxt;
      frame_open_r <= frame_open_nxt;
      lat_w_r      <= lat_w_nxt;
      lat_h_r      <= lat_h_nxt;
      lat_rx_r     <= lat_rx_nxt;
      lat_ry_r     <= lat_ry_nxt;
      lag_r        <= lag_nxt;
      diff_r       <= diff_nxt;
      in_col_r     <= in_col_nxt;
      in_row_r     <= in_row_nxt;
      in_slot_r    <= in_slot_nxt;
      out_col_r    <= out_col_nxt;
      out_row_r    <= out_row_nxt;
      out_slot_r   <= out_slot_nxt;
      out_valid_r  <= out_valid_nxt;
      iss1_r       <= (state_r == S_TAP);
      iss2_r       <= iss1_r;
      v1_r         <= (state_r == S_TAP) && tap_inb;
      v2_r         <= v1_r;
      cnt_r        <= cnt_nxt;
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_IMAGE_WIDTH:  cfg_w_r  <= cfg_data;
          REG_IMAGE_HEIGHT: cfg_h_r  <= cfg_data;
          REG_RADIUS_X:     cfg_rx_r <= cfg_data[1:0];
          REG_RADIUS_Y:     cfg_ry_r <= cfg_data[1:0];
        endcase
      end
    end
  end

  // Payload and datapath registers.
  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    ti_r       <= ti_nxt;
    tj_r       <= tj_nxt;
    kidx_r     <= kidx_nxt;
    tslot_r    <= tslot_nxt;
    cf2_r      <= $signed(coef_q);
    asum_r     <= asum_nxt;
    d_r        <= d_nxt;
    dsh_r      <= dsh_nxt;
    neg_r      <= neg_nxt;
    ovf_r      <= ovf_nxt;
    azero_r    <= azero_nxt;
    out_data_r <= out_data_nxt;
    for (int c = 0; c < 3; c++) begin
      p_r[c]   <= p_nxt[c];
      acc_r[c] <= acc_nxt[c];
      n_r[c]   <= n_nxt[c];
      q_r[c]   <= q_nxt[c];
    end
  end

  // The count of pixels written ahead of the outputs never passes the lag plus one.
  a_diff_bound: assert property (@(posedge clk) disable iff (!rst_n)
    frame_open_r |-> ({1'b0, diff_r} <= ({1'b0, lag_r} + 1'b1)))
    else $error("row store fill ran ahead of the output position");

  a_tap_open: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TAP) |-> (frame_open_r && (out_row_r < lat_h_r)))
    else $error("tap sweep started without a pending output");

  a_tap_index: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TAP) |-> (32'(kidx_r) < 32'(KTAPS)))
    else $error("kernel index beyond the coefficient store");

  a_frame_close: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (out_data_r.frame_end == !frame_open_r))
    else $error("frame end flag disagrees with the frame state");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !out_load)
    else $error("result loaded over one that has not been transferred");

endmodule
